// ----- design/argmm_pkg.sv -----
package argmm_pkg;

    localparam int LANES   = 8;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 4;
    localparam int LANE_W  = $clog2(LANES);
    localparam int LEVELS  = LANE_W;
    localparam int PAD     = 1 << LEVELS;
    localparam int CW      = (LANE_W > IDX_W) ? LANE_W : IDX_W;
    localparam int IN_W    = ((LANES * VAL_W + 7) / 8) * 8;
    localparam int OUT_RAW = 3 * IDX_W + 3 * VAL_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 4;

    typedef enum logic [1:0] {
        MODE_MAX  = 2'd0,
        MODE_MIN  = 2'd1,
        MODE_AMAX = 2'd2,
        MODE_AMIN = 2'd3
    } t_mode;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MODE  = 2'd0,
        CFG_COUNT = 2'd1,
        CFG_LOW   = 2'd2,
        CFG_HIGH  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_mode              mode;
        logic [CNT_W-1:0]   lane_count;
        logic [IDX_W-1:0]   index_low;
        logic [IDX_W-1:0]   index_high;
    } t_cfg;

    typedef logic [LANES-1:0][VAL_W-1:0] t_lanes;

    typedef struct packed {
        logic [LANES-1:0] ok;
        t_lanes           val;
    } t_vec;

    function automatic logic want_min(t_mode m);
        return (m == MODE_MIN) || (m == MODE_AMIN);
    endfunction

    function automatic logic want_mag(t_mode m);
        return (m == MODE_AMAX) || (m == MODE_AMIN);
    endfunction

    // indices past the last lane read the last lane
    function automatic logic [LANE_W-1:0] lane_of(logic [IDX_W-1:0] idx);
        logic [CW-1:0] x;
        x = CW'(idx);
        if (x >= CW'(LANES - 1)) begin
            return LANE_W'(LANES - 1);
        end
        return x[LANE_W-1:0];
    endfunction

endpackage

// ----- design/argmax_argmin_with_neighbours.sv -----
// Channel    Dir  Data                                          Handshake
// s_axis     in   sample0..sample7, 32 b each, lowest first     tvalid/tready
// m_axis     out  best/prev/next index, best/prev/next value    tvalid/tready
// i_cfg_*    in   mode, lane_count, index_low, index_high       i_cfg_we
//
// One beat per cycle sustained while m_axis_tready stays high; stages in order:
// magnitude stage, one compare level per stage, clamp and lane select stage.
// Synchronous reset clears the valid bits and loads the register defaults.
// Each stage holds while its successor is full and stalled; bubbles close up.
module argmax_argmin_with_neighbours
    import argmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,  // sample0 .. sample7
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata   // best_index, prev_index, next_index,
                                             // best_value, prev_value, next_value
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_MAX;
            r_cfg.lane_count <= CNT_W'(LANES);
            r_cfg.index_low  <= '0;
            r_cfg.index_high <= IDX_W'(7);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_MODE:  r_cfg.mode       <= t_mode'(i_cfg_data[1:0]);
                CFG_COUNT: r_cfg.lane_count <= i_cfg_data[CNT_W-1:0];
                CFG_LOW:   r_cfg.index_low  <= i_cfg_data[IDX_W-1:0];
                CFG_HIGH:  r_cfg.index_high <= i_cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    logic              prep_valid;
    logic              prep_ready;
    t_vec              prep_vec;
    logic              tree_valid;
    logic              tree_ready;
    logic [LANE_W-1:0] tree_idx;
    t_lanes            tree_lanes;

    argmm_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_lanes (t_lanes'(s_axis_tdata[LANES*VAL_W-1:0])),
        .o_valid (prep_valid),
        .i_ready (prep_ready),
        .o_vec   (prep_vec)
    );

    argmm_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_cfg.mode),
        .i_valid (prep_valid),
        .o_ready (prep_ready),
        .i_vec   (prep_vec),
        .o_valid (tree_valid),
        .i_ready (tree_ready),
        .o_idx   (tree_idx),
        .o_lanes (tree_lanes)
    );

    argmm_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (tree_valid),
        .o_ready (tree_ready),
        .i_idx   (tree_idx),
        .i_lanes (tree_lanes),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

// ----- design/argmm_prep.sv -----
module argmm_prep
    import argmm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_lanes i_lanes,
    output logic   o_valid,
    input  logic   i_ready,
    output t_vec   o_vec
);

    logic r_valid;
    t_vec r_vec;
    t_vec n_vec;

    always_comb begin
        logic [VAL_W-1:0] s;
        n_vec = '0;
        for (int i = 0; i < LANES; i++) begin
            s = i_lanes[i];
            if (want_mag(i_cfg.mode)) begin
                if (s == {1'b1, {(VAL_W-1){1'b0}}}) begin
                    s = {1'b0, {(VAL_W-1){1'b1}}};
                end else if (s[VAL_W-1]) begin
                    s = -s;
                end
            end
            n_vec.val[i] = s;
            n_vec.ok[i]  = ((CNT_W+1)'(i) < {1'b0, i_cfg.lane_count});
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

// ----- design/argmm_tree.sv -----
module argmm_tree
    import argmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mode             i_mode,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_vec              i_vec,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [LANE_W-1:0] o_idx,
    output t_lanes            o_lanes
);

    // level 0 is the incoming vector, levels 1..LEVELS are registered
    logic   [LEVELS:0]                        lv_valid;
    logic   [LEVELS:0][PAD-1:0][LANE_W-1:0]   lv_idx;
    logic   [LEVELS:0][PAD-1:0][VAL_W-1:0]    lv_val;
    logic   [LEVELS:0][PAD-1:0]               lv_ok;
    t_lanes [LEVELS:0]                        lv_lanes;

    logic   [LEVELS:1]                        r_valid;
    logic   [LEVELS:1][PAD-1:0][LANE_W-1:0]   r_idx;
    logic   [LEVELS:1][PAD-1:0][VAL_W-1:0]    r_val;
    logic   [LEVELS:1][PAD-1:0]               r_ok;
    t_lanes [LEVELS:1]                        r_lanes;

    logic   [LEVELS:1][PAD-1:0][LANE_W-1:0]   n_idx;
    logic   [LEVELS:1][PAD-1:0][VAL_W-1:0]    n_val;
    logic   [LEVELS:1][PAD-1:0]               n_ok;

    logic   [LEVELS+1:1]                      rdy;

    always_comb begin
        lv_valid[0] = i_valid;
        lv_lanes[0] = i_vec.val;
        for (int j = 0; j < PAD; j++) begin
            lv_idx[0][j] = LANE_W'(j);
            lv_val[0][j] = (j < LANES) ? i_vec.val[j] : '0;
            lv_ok[0][j]  = (j < LANES) ? i_vec.ok[j] : 1'b0;
        end
        for (int l = 1; l <= LEVELS; l++) begin
            lv_valid[l] = r_valid[l];
            lv_idx[l]   = r_idx[l];
            lv_val[l]   = r_val[l];
            lv_ok[l]    = r_ok[l];
            lv_lanes[l] = r_lanes[l];
        end
    end

    // pairwise compare; lower lane keeps a tie
    always_comb begin
        logic take_b;
        logic lt;
        logic gt;
        n_idx = '0;
        n_val = '0;
        n_ok  = '0;
        for (int l = 1; l <= LEVELS; l++) begin
            for (int j = 0; j < PAD; j++) begin
                if (j < (PAD >> l)) begin
                    lt = $signed(lv_val[l-1][2*j+1]) < $signed(lv_val[l-1][2*j]);
                    gt = $signed(lv_val[l-1][2*j+1]) > $signed(lv_val[l-1][2*j]);
                    take_b = lv_ok[l-1][2*j+1] &&
                             (!lv_ok[l-1][2*j] || (want_min(i_mode) ? lt : gt));
                    n_idx[l][j] = take_b ? lv_idx[l-1][2*j+1] : lv_idx[l-1][2*j];
                    n_val[l][j] = take_b ? lv_val[l-1][2*j+1] : lv_val[l-1][2*j];
                    n_ok[l][j]  = lv_ok[l-1][2*j] || lv_ok[l-1][2*j+1];
                end
            end
        end
    end

    always_comb begin
        rdy[LEVELS+1] = i_ready;
        for (int l = LEVELS; l >= 1; l--) begin
            rdy[l] = !r_valid[l] || rdy[l+1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 1; l <= LEVELS; l++) begin
            if (!i_rst_n) begin
                r_valid[l] <= 1'b0;
            end else if (rdy[l]) begin
                r_valid[l] <= lv_valid[l-1];
            end
            if (rdy[l] && lv_valid[l-1]) begin
                r_idx[l]   <= n_idx[l];
                r_val[l]   <= n_val[l];
                r_ok[l]    <= n_ok[l];
                r_lanes[l] <= lv_lanes[l-1];
            end
        end
    end

    assign o_ready = rdy[1];
    assign o_valid = lv_valid[LEVELS];
    assign o_idx   = lv_idx[LEVELS][0];
    assign o_lanes = lv_lanes[LEVELS];

endmodule

// ----- design/argmm_pick.sv -----
module argmm_pick
    import argmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [LANE_W-1:0] i_idx,
    input  t_lanes            i_lanes,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_data
);

    logic             r_valid;
    logic [OUT_W-1:0] r_data;
    logic [OUT_W-1:0] n_data;

    always_comb begin
        logic [CW-1:0]    b;
        logic [CW-1:0]    lo;
        logic [CW-1:0]    hi;
        logic [IDX_W-1:0] best;
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] next;
        logic [IDX_W-1:0] pm;
        logic [IDX_W:0]   nx;
        b  = CW'(i_idx);
        lo = CW'(i_cfg.index_low);
        hi = CW'(i_cfg.index_high);
        if (b > hi) begin
            b = hi;
        end
        if (b < lo) begin
            b = lo;
        end
        best = IDX_W'(b);
        pm   = best - 1'b1;
        if (best == '0 || pm < i_cfg.index_low) begin
            prev = i_cfg.index_low;
        end else begin
            prev = pm;
        end
        nx = {1'b0, best} + 1'b1;
        if (nx > {1'b0, i_cfg.index_high}) begin
            next = i_cfg.index_high;
        end else begin
            next = nx[IDX_W-1:0];
        end
        n_data = OUT_W'({i_lanes[lane_of(next)], i_lanes[lane_of(prev)],
                         i_lanes[lane_of(best)], next, prev, best});
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- design/argmm_chk.sv -----
module argmm_chk
    import argmm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic [IDX_W-1:0] best;
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] next;

    assign best = m_axis_tdata[IDX_W-1:0];
    assign prev = m_axis_tdata[2*IDX_W-1:IDX_W];
    assign next = m_axis_tdata[3*IDX_W-1:2*IDX_W];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled beat changed");

    a_prev_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> prev <= best)
        else $error("prev index above best index");

    a_next_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> {1'b0, next} <= {1'b0, best} + 1'b1)
        else $error("next index beyond best plus one");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> OUT_RAW) == '0)
        else $error("padding bits set");

endmodule

bind argmax_argmin_with_neighbours argmm_chk u_argmm_chk (.*);
